[hw/rtl/chsp_pkg.sv]
// Shared constants and types of the coalesced hash slot placer.
package chsp_pkg;

   localparam int TABLE_SLOTS = 1024;
   localparam int SLOT_W      = 10;
   localparam int LINK_W      = 11;
   localparam int COUNT_W     = 11;
   localparam int SUM_W       = 18;
   localparam int STEP_W      = 11;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [LINK_W-1:0]  NO_LINK  = LINK_W'(TABLE_SLOTS);
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(TABLE_SLOTS);

   // One queued byte event: only last bytes and set starts reach the back end.
   typedef struct packed {
      logic             fresh;
      logic             last;
      logic [SUM_W-1:0] sum;
   } chsp_item_type;

   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
   } chsp_mod_req_type;

   typedef struct packed {
      logic              done;
      logic [SLOT_W-1:0] remainder;
   } chsp_mod_rsp_type;

endpackage

[hw/rtl/chsp_front.sv]
// Front end: folds and sums name bytes, queues last bytes and set starts.
module chsp_front
   import chsp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          byte_valid,
   output logic          byte_ready,
   input  logic [7:0]    name_byte,
   input  logic          last_byte,
   input  logic          new_set,
   input  logic          queue_full,
   output logic          push,
   output chsp_item_type push_item
);

   logic [SUM_W-1:0] sum_ff, sum_in, sum_next;
   logic [7:0]       folded;

   always_comb begin
      folded = name_byte;
      if (name_byte >= 8'h41 && name_byte <= 8'h5A) begin
         folded = name_byte + 8'h20;
      end
      sum_next = (new_set ? '0 : sum_ff) + SUM_W'(folded);
   end

   assign byte_ready = !queue_full;
   assign push       = byte_valid && byte_ready && (last_byte || new_set);
   assign push_item  = '{fresh: new_set, last: last_byte, sum: sum_next};

   always_comb begin
      sum_in = sum_ff;
      if (byte_valid && byte_ready) begin
         sum_in = last_byte ? '0 : sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

endmodule

[hw/rtl/chsp_queue.sv]
// Short queue between the front and back ends.
module chsp_queue
   import chsp_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  chsp_item_type push_item,
   output logic          full,
   input  logic          pop,
   output logic          not_empty,
   output chsp_item_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   chsp_item_type            store_ff [DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]         count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[hw/rtl/chsp_mod.sv]
// Restoring remainder unit: one dividend bit per cycle.
module chsp_mod
   import chsp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  chsp_mod_req_type req,
   input  logic [COUNT_W-1:0] divisor,
   output chsp_mod_rsp_type rsp
);

   localparam int CNT_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  shift_ff, shift_in;
   logic [SLOT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [COUNT_W-1:0] trial;

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, shift_ff[SUM_W-1]};
      if (req.start) begin
         shift_in = req.dividend;
         rem_in   = '0;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so it fits SLOT_W bits.
         if (trial >= divisor) begin
            trial = trial - divisor;
         end
         rem_in   = trial[SLOT_W-1:0];
         shift_in = {shift_ff[SUM_W-2:0], 1'b0};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign rsp = '{done: done_ff, remainder: rem_ff};

endmodule

[hw/rtl/chsp_back.sv]
// Back end: table memory, chain walk, free-slot scan and result register.
module chsp_back
   import chsp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               q_not_empty,
   input  chsp_item_type      q_head,
   output logic               q_pop,
   input  logic [COUNT_W-1:0] eff_count,
   input  logic               cfg_write,
   input  logic [COUNT_W-1:0] cfg_count,
   output chsp_mod_req_type   mod_req,
   input  chsp_mod_rsp_type   mod_rsp,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata,
   output logic [1:0]         rsp_tuser
);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_START, S_DIV, S_RD, S_WALK, S_HOME_WR,
      S_SCAN_RD, S_SCAN_CHK, S_LINK_WR, S_NEW_WR, S_EMIT
   } state_type;

   localparam int WORD_W = LINK_W + 1;

   // Each word holds the occupied flag above the next link.
   logic [WORD_W-1:0] table_mem [TABLE_SLOTS];
   logic [WORD_W-1:0] rdata_ff;
   logic [SLOT_W-1:0] addr_ff, addr_in;

   state_type          state_ff, state_in;
   logic               pend_last_ff, pend_last_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [SLOT_W-1:0]  clr_ff, clr_in, home_ff, home_in, tail_ff, tail_in;
   logic [SLOT_W-1:0]  scan_ff, scan_in, slot_ff, slot_in, from_ff, from_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic [COUNT_W-1:0] fp_ff, fp_in;
   logic               home_ok_ff, home_ok_in, drop_ff, drop_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [23:0]        rsp_data_ff, rsp_data_in;
   logic [1:0]         rsp_user_ff, rsp_user_in;

   logic               wr_en;
   logic [SLOT_W-1:0]  wr_addr;
   logic [WORD_W-1:0]  wr_data;
   logic [COUNT_W-1:0] eff_m1, cfg_m1;
   logic [SLOT_W-1:0]  scan_start;

   assign eff_m1     = eff_count - 1'b1;
   assign cfg_m1     = cfg_count - 1'b1;
   assign scan_start = (fp_ff < eff_count) ? fp_ff[SLOT_W-1:0] : eff_m1[SLOT_W-1:0];

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = {1'b0, NO_LINK};
      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
         end
         S_HOME_WR: begin
            wr_en   = 1'b1;
            wr_addr = home_ff;
            wr_data = {1'b1, NO_LINK};
         end
         S_LINK_WR: begin
            wr_en   = 1'b1;
            wr_addr = tail_ff;
            wr_data = {1'b1, 1'b0, scan_ff};
         end
         S_NEW_WR: begin
            wr_en   = 1'b1;
            wr_addr = scan_ff;
            wr_data = {1'b1, NO_LINK};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= table_mem[addr_ff];
   end

   always_comb begin
      state_in     = state_ff;
      pend_last_in = pend_last_ff;
      sum_in       = sum_ff;
      clr_in       = clr_ff;
      home_in      = home_ff;
      tail_in      = tail_ff;
      scan_in      = scan_ff;
      slot_in      = slot_ff;
      from_in      = from_ff;
      steps_in     = steps_ff;
      fp_in        = fp_ff;
      home_ok_in   = home_ok_ff;
      drop_in      = drop_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      q_pop        = 1'b0;
      mod_req      = '{start: 1'b0, dividend: sum_ff};

      if (cfg_write) begin
         fp_in = cfg_m1;
      end

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SLOT_W'(TABLE_SLOTS - 1)) begin
               state_in = pend_last_ff ? S_START : S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_not_empty) begin
               q_pop        = 1'b1;
               sum_in       = q_head.sum;
               pend_last_in = q_head.last;
               if (q_head.fresh) begin
                  clr_in   = '0;
                  fp_in    = eff_m1;
                  state_in = S_CLEAR;
               end else begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            mod_req.start = 1'b1;
            state_in      = S_DIV;
         end
         S_DIV: begin
            if (mod_rsp.done) begin
               home_in  = mod_rsp.remainder;
               tail_in  = mod_rsp.remainder;
               addr_in  = mod_rsp.remainder;
               steps_in = '0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_WALK;
         end
         S_WALK: begin
            if (steps_ff == '0 && !rdata_ff[WORD_W-1]) begin
               slot_in    = home_ff;
               from_in    = '0;
               home_ok_in = 1'b1;
               drop_in    = 1'b0;
               state_in   = S_HOME_WR;
            end else if (!rdata_ff[LINK_W-1] && steps_ff != STEP_W'(TABLE_SLOTS)) begin
               tail_in  = rdata_ff[SLOT_W-1:0];
               addr_in  = rdata_ff[SLOT_W-1:0];
               steps_in = steps_ff + 1'b1;
               state_in = S_RD;
            end else begin
               scan_in  = scan_start;
               addr_in  = scan_start;
               state_in = S_SCAN_RD;
            end
         end
         S_HOME_WR: begin
            state_in = S_EMIT;
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            if (!rdata_ff[WORD_W-1]) begin
               fp_in    = COUNT_W'(scan_ff);
               state_in = S_LINK_WR;
            end else if (scan_ff == '0) begin
               fp_in      = '0;
               slot_in    = '0;
               from_in    = '0;
               home_ok_in = 1'b0;
               drop_in    = 1'b1;
               state_in   = S_EMIT;
            end else begin
               scan_in  = scan_ff - 1'b1;
               addr_in  = scan_ff - 1'b1;
               state_in = S_SCAN_RD;
            end
         end
         S_LINK_WR: begin
            state_in = S_NEW_WR;
         end
         S_NEW_WR: begin
            slot_in    = scan_ff;
            from_in    = tail_ff;
            home_ok_in = 1'b0;
            drop_in    = 1'b0;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, from_ff, slot_ff};
               rsp_user_in  = {drop_ff, home_ok_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         pend_last_ff <= 1'b0;
         clr_ff       <= '0;
         fp_ff        <= MAX_COUNT - 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_last_ff <= pend_last_in;
         clr_ff       <= clr_in;
         fp_ff        <= fp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sum_ff      <= sum_in;
      home_ff     <= home_in;
      tail_ff     <= tail_in;
      scan_ff     <= scan_in;
      slot_ff     <= slot_in;
      from_ff     <= from_in;
      steps_ff    <= steps_in;
      home_ok_ff  <= home_ok_in;
      drop_ff     <= drop_in;
      addr_ff     <= addr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

[hw/rtl/coalesced_hash_slot_placer_core.sv]
// Top level of the coalesced hash slot placer.
//
// Name bytes enter on the req_ stream, one per beat; req_tlast marks the last
// byte of a name and req_tuser (new_set) clears the table before its byte.
// The front end takes one beat per cycle while its four-entry queue has room.
// Each last byte yields one rsp_ beat with the placed slot, the chain tail
// linked to it, and at_home / dropped flags. Placements run one at a time.
// The back end finds the home slot in a bit-serial remainder unit over the 18
// dividend bits, then walks the chain and scans for a free slot on the table
// memory, then writes the home slot, or a link and a new slot, and then loads
// the result register.
// A new set, and reset itself, sweep all 1024 table words, one per cycle,
// before the next name is placed; bytes keep queuing meanwhile.
// The user must write bucket_count on the csr_ port only while the block is idle;
// it is not enforced. A stalled receiver holds the result register; the back end
// finishes the next placement and waits; the queue fills before req_tready drops.
module coalesced_hash_slot_placer_core
   import chsp_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // [7:0] name_byte
   input  logic               req_tlast,
   input  logic               req_tuser,   // [0] new_set
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata,   // [9:0] slot_index, [19:10] linked_from
   output logic [1:0]         rsp_tuser,   // [0] at_home, [1] dropped
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_data
);

   chsp_item_type      push_item, head;
   logic               push, full, pop, not_empty;
   chsp_mod_req_type   mod_req;
   chsp_mod_rsp_type   mod_rsp;
   logic [COUNT_W-1:0] eff_ff, eff_in, csr_eff;
   logic               csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      csr_eff = csr_data;
      if (csr_data == '0) begin
         csr_eff = COUNT_W'(1);
      end else if (csr_data > MAX_COUNT) begin
         csr_eff = MAX_COUNT;
      end
      eff_in = csr_write ? csr_eff : eff_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_ff <= MAX_COUNT;
      end else begin
         eff_ff <= eff_in;
      end
   end

   chsp_front u_front (
      .clock(clock), .reset(reset),
      .byte_valid(req_tvalid), .byte_ready(req_tready),
      .name_byte(req_tdata), .last_byte(req_tlast), .new_set(req_tuser),
      .queue_full(full), .push(push), .push_item(push_item)
   );

   chsp_queue #(.DEPTH(QUEUE_DEPTH_P)) u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_item(push_item), .full(full),
      .pop(pop), .not_empty(not_empty), .head(head)
   );

   chsp_mod u_mod (
      .clock(clock), .reset(reset),
      .req(mod_req), .divisor(eff_ff), .rsp(mod_rsp)
   );

   chsp_back u_back (
      .clock(clock), .reset(reset),
      .q_not_empty(not_empty), .q_head(head), .q_pop(pop),
      .eff_count(eff_ff), .cfg_write(csr_write), .cfg_count(csr_eff),
      .mod_req(mod_req), .mod_rsp(mod_rsp),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tdata == '0 && !rsp_tuser[0])
      else $error("dropped result carries a slot or link");

   a_home_no_link: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[19:10] == '0)
      else $error("home placement reports a link");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> COUNT_W'(rsp_tdata[9:0]) < eff_ff)
      else $error("slot beyond bucket count");

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue overflow");

endmodule
